FILE: rtl/core/clt_pkg.sv
// Shared types and constants for the cotangent Laplacian triangle weight block.
// Used by clt_corner_pipe and the top level; depends on nothing else.
`default_nettype none
package clt_pkg;

    localparam int VERT_W        = 20;   // vertex index field
    localparam int EDGE_W        = 32;   // input edge length field, unsigned Q16.16
    localparam int LEN_W         = 31;   // edge length after range reduction
    localparam int FRACTION_BITS = 16;   // weight fraction bits
    localparam int WEIGHT_W      = 32;   // signed Q16.16 weight
    localparam int SQ_W          = 2 * LEN_W;           // squared length
    localparam int SUM_W         = SQ_W + 1;            // sum of two squares
    localparam int DREM_W        = SUM_W + 1;           // cosine divider remainder
    localparam int COS_W         = 30;                  // cosine magnitude fraction bits
    localparam int QQ_W          = 2 * COS_W;           // cosine squared
    localparam int V_W           = QQ_W + 1;            // 1 - cos^2, up to 2^60
    localparam int SV_W          = V_W + 1;             // even width for digit pairs
    localparam int ROOT_W        = SV_W / 2;            // floor square root bits
    localparam int SREM_W        = ROOT_W + 4;          // square root remainder
    localparam int QW            = WEIGHT_W - 1;        // weight magnitude bits
    localparam int NUM_W         = COS_W + FRACTION_BITS + 1;
    localparam int D2_W          = ROOT_W + 1;          // twice the root
    localparam int R2_W          = D2_W + 1;            // weight divider remainder
    localparam logic [QW-1:0] MAXW = {QW{1'b1}};

    // Pipeline depth of the corner unit
    localparam int NSTG = 4 + COS_W + 2 + ROOT_W + 1 + QW + 1;

    // One corner entering the corner unit
    typedef struct packed {
        logic [LEN_W-1:0]  opp;
        logic [LEN_W-1:0]  s1;
        logic [LEN_W-1:0]  s2;
        logic [VERT_W-1:0] vi;
        logic [VERT_W-1:0] vj;
        logic              last;
    } corner_in_t;

    // Tag and flags that travel with a corner through the pipe
    typedef struct packed {
        logic [VERT_W-1:0] vi;
        logic [VERT_W-1:0] vj;
        logic              last;
        logic              neg;
        logic              zero;
        logic              sat;
    } ctag_t;

    // One finished corner: half cotangent and its vertices
    typedef struct packed {
        logic [VERT_W-1:0]          vi;
        logic [VERT_W-1:0]          vj;
        logic                       last;
        logic                       degen;
        logic signed [WEIGHT_W-1:0] weight;
    } corner_out_t;

    // Triplet order within one corner
    typedef enum logic [1:0] {
        TRIP_IJ,
        TRIP_JI,
        TRIP_II,
        TRIP_JJ
    } trip_t;

endpackage
`default_nettype wire

FILE: rtl/core/clt_corner_pipe.sv
// Corner unit: law of cosines, cosine division, square root and weight division,
// one bit step per register stage. Depends on clt_pkg.
`default_nettype none
module clt_corner_pipe
    import clt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire corner_in_t  in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output corner_out_t      out_data
);

    logic            adv;
    logic [NSTG-1:0] vld_reg;
    ctag_t           tag_reg [NSTG];

    // Squares and products
    logic [SQ_W-1:0]  a2_reg, s1s_reg, s2s_reg, p_reg;
    // Sum stage
    logic [SUM_W-1:0] sum_reg, a2b_reg, den1_reg;
    // Magnitude stage
    logic [SUM_W-1:0] mag_reg, den2_reg;
    logic             neg_next;
    logic [SUM_W-1:0] mag_next;

    // Cosine divider
    logic [DREM_W-1:0] drem_reg [COS_W+1];
    logic [SUM_W-1:0]  dden_reg [COS_W+1];
    logic [COS_W-1:0]  dq_reg   [COS_W+1];
    logic [DREM_W-1:0] drem_next [COS_W];
    logic [COS_W-1:0]  dq_next   [COS_W];

    // Cosine squared and 1 - cos^2
    logic [QQ_W-1:0]  qq_reg;
    logic [COS_W-1:0] qa_reg;
    logic [V_W-1:0]   v_next;

    // Square root
    logic [SV_W-1:0]   sv_reg   [ROOT_W+1];
    logic [SREM_W-1:0] srem_reg [ROOT_W+1];
    logic [ROOT_W-1:0] sroot_reg[ROOT_W+1];
    logic [COS_W-1:0]  sq_reg   [ROOT_W+1];
    logic [SREM_W-1:0] srem_next [ROOT_W];
    logic [ROOT_W-1:0] sroot_next[ROOT_W];

    // Weight divider
    logic [R2_W-1:0]  wrem_reg [QW+1];
    logic [QW-1:0]    wnb_reg  [QW+1];
    logic [QW-1:0]    wq_reg   [QW+1];
    logic [D2_W-1:0]  wd_reg   [QW+1];
    logic             wovf_reg [QW+1];
    logic [R2_W-1:0]  wrem_next [QW];
    logic [QW-1:0]    wq_next   [QW];
    logic [NUM_W-1:0] num_next;
    logic [D2_W-1:0]  d2_next;

    // Final weight
    corner_out_t      res_reg;
    corner_out_t      res_next;
    logic [QW-1:0]    mag_fin;

    // Advance the whole pipe unless the last stage is held
    assign adv       = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // Move the tag, setting flags where they are found
    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0] <= '{vi: in_data.vi, vj: in_data.vj, last: in_data.last,
                            neg: 1'b0, zero: 1'b0, sat: 1'b0};
            tag_reg[1] <= tag_reg[0];
            tag_reg[2] <= '{vi: tag_reg[1].vi, vj: tag_reg[1].vj, last: tag_reg[1].last,
                            neg: neg_next, zero: 1'b0, sat: 1'b0};
            tag_reg[3] <= '{vi: tag_reg[2].vi, vj: tag_reg[2].vj, last: tag_reg[2].last,
                            neg: tag_reg[2].neg, zero: (den2_reg == '0),
                            sat: (mag_reg >= den2_reg)};
            for (int s = 4; s < NSTG; s++) begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    // Law of cosines front end
    assign neg_next = a2b_reg > sum_reg;
    assign mag_next = neg_next ? a2b_reg - sum_reg : sum_reg - a2b_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a2_reg   <= {{LEN_W{1'b0}}, in_data.opp} * {{LEN_W{1'b0}}, in_data.opp};
            s1s_reg  <= {{LEN_W{1'b0}}, in_data.s1} * {{LEN_W{1'b0}}, in_data.s1};
            s2s_reg  <= {{LEN_W{1'b0}}, in_data.s2} * {{LEN_W{1'b0}}, in_data.s2};
            p_reg    <= {{LEN_W{1'b0}}, in_data.s1} * {{LEN_W{1'b0}}, in_data.s2};
            sum_reg  <= {1'b0, s1s_reg} + {1'b0, s2s_reg};
            a2b_reg  <= {1'b0, a2_reg};
            den1_reg <= {p_reg, 1'b0};
            mag_reg  <= mag_next;
            den2_reg <= den1_reg;
        end
    end

    // Cosine divider: one quotient bit per stage
    always_comb begin
        for (int d = 0; d < COS_W; d++) begin
            logic [DREM_W-1:0] sh;
            sh = {drem_reg[d][DREM_W-2:0], 1'b0};
            if (sh >= {1'b0, dden_reg[d]}) begin
                drem_next[d] = sh - {1'b0, dden_reg[d]};
                dq_next[d]   = {dq_reg[d][COS_W-2:0], 1'b1};
            end else begin
                drem_next[d] = sh;
                dq_next[d]   = {dq_reg[d][COS_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            drem_reg[0] <= {1'b0, mag_reg};
            dden_reg[0] <= den2_reg;
            dq_reg[0]   <= '0;
            for (int d = 0; d < COS_W; d++) begin
                drem_reg[d+1] <= drem_next[d];
                dden_reg[d+1] <= dden_reg[d];
                dq_reg[d+1]   <= dq_next[d];
            end
        end
    end

    // Square the cosine, then form 1 - cos^2
    assign v_next = {1'b1, {QQ_W{1'b0}}} - {1'b0, qq_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            qq_reg <= {{COS_W{1'b0}}, dq_reg[COS_W]} * {{COS_W{1'b0}}, dq_reg[COS_W]};
            qa_reg <= dq_reg[COS_W];
        end
    end

    // Square root: one root bit per stage
    always_comb begin
        for (int s = 0; s < ROOT_W; s++) begin
            logic [SREM_W-1:0] r2;
            logic [SREM_W-1:0] trial;
            r2    = {srem_reg[s][SREM_W-3:0], sv_reg[s][SV_W-1:SV_W-2]};
            trial = {2'b0, sroot_reg[s], 2'b01} >> 0;
            if (r2 >= trial) begin
                srem_next[s]  = r2 - trial;
                sroot_next[s] = {sroot_reg[s][ROOT_W-2:0], 1'b1};
            end else begin
                srem_next[s]  = r2;
                sroot_next[s] = {sroot_reg[s][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sv_reg[0]    <= {1'b0, v_next};
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
            sq_reg[0]    <= qa_reg;
            for (int s = 0; s < ROOT_W; s++) begin
                sv_reg[s+1]    <= {sv_reg[s][SV_W-3:0], 2'b00};
                srem_reg[s+1]  <= srem_next[s];
                sroot_reg[s+1] <= sroot_next[s];
                sq_reg[s+1]    <= sq_reg[s];
            end
        end
    end

    // Rounded weight division setup: (q << FRACTION_BITS + r) / (2 r)
    assign num_next = {1'b0, sq_reg[ROOT_W], {FRACTION_BITS{1'b0}}}
                    + {{(NUM_W-ROOT_W){1'b0}}, sroot_reg[ROOT_W]};
    assign d2_next  = {sroot_reg[ROOT_W], 1'b0};

    always_comb begin
        for (int w = 0; w < QW; w++) begin
            logic [R2_W-1:0] sh;
            sh = {wrem_reg[w][R2_W-2:0], wnb_reg[w][QW-1]};
            if (sh >= {1'b0, wd_reg[w]}) begin
                wrem_next[w] = sh - {1'b0, wd_reg[w]};
                wq_next[w]   = {wq_reg[w][QW-2:0], 1'b1};
            end else begin
                wrem_next[w] = sh;
                wq_next[w]   = {wq_reg[w][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wrem_reg[0] <= R2_W'(num_next[NUM_W-1:QW]);
            wnb_reg[0]  <= num_next[QW-1:0];
            wq_reg[0]   <= '0;
            wd_reg[0]   <= d2_next;
            wovf_reg[0] <= R2_W'(num_next[NUM_W-1:QW]) >= {1'b0, d2_next};
            for (int w = 0; w < QW; w++) begin
                wrem_reg[w+1] <= wrem_next[w];
                wnb_reg[w+1]  <= {wnb_reg[w][QW-2:0], 1'b0};
                wq_reg[w+1]   <= wq_next[w];
                wd_reg[w+1]   <= wd_reg[w];
                wovf_reg[w+1] <= wovf_reg[w];
            end
        end
    end

    // Clamp, apply special cases and sign
    always_comb begin
        ctag_t t;
        t = tag_reg[NSTG-2];
        if (t.zero) begin
            mag_fin = '0;
        end else if (t.sat || wovf_reg[QW]) begin
            mag_fin = MAXW;
        end else begin
            mag_fin = wq_reg[QW];
        end
        res_next.vi     = t.vi;
        res_next.vj     = t.vj;
        res_next.last   = t.last;
        res_next.degen  = t.zero || t.sat;
        res_next.weight = t.neg ? -$signed({1'b0, mag_fin}) : $signed({1'b0, mag_fin});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A degenerate corner carries zero or a saturated weight
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_data.degen |->
            out_data.weight == 0 || out_data.weight == $signed({1'b0, MAXW})
            || out_data.weight == -$signed({1'b0, MAXW}))
        else $error("degenerate corner with ordinary weight");
    // A held result stays while the pipe is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("corner result changed during stall");
    // An empty last stage never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid |-> in_ready)
        else $error("input blocked with empty last stage");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/cotangent_laplacian_triangle_weights_top.sv
// A triangle's three corners enter the corner pipe in turn while it is ready;
// the corner pipe has 100 stages, and a hold register follows it.
// The output channel sets the triangle rate: it moves one triplet per cycle
// while m_tready is high (four per corner, twelve per triangle), and a new
// triangle can be taken while the previous one's last corner is issued.
// Reset: aresetn synchronous, active low; clears all valid bits and counters.
// Depends on clt_pkg and clt_corner_pipe.
`default_nettype none
module cotangent_laplacian_triangle_weights_top
    import clt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata from bit 0: edge_len_0, edge_len_1, edge_len_2, vert_0, vert_1, vert_2, pad
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata from bit 0: row_index, col_index, weight
    output logic [71:0]       m_tdata,
    // m_tlast: last_of_triangle
    output logic              m_tlast,
    // m_tuser: degenerate
    output logic              m_tuser
);

    logic [LEN_W-1:0]  len_reg  [3];
    logic [VERT_W-1:0] vert_reg [3];
    logic              tri_vld_reg;
    logic [1:0]        cidx_reg;
    logic [EDGE_W-1:0] e0, e1, e2;
    logic              big;

    corner_in_t  cin;
    logic        pipe_ready;
    logic        pipe_valid;
    corner_out_t pipe_data;
    logic        hold_take;

    corner_out_t hold_reg;
    logic        hv_reg;
    trip_t       trip_reg;
    logic        m_fire;

    // Reduce range when any length uses the top bit
    assign e0  = s_tdata[31:0];
    assign e1  = s_tdata[63:32];
    assign e2  = s_tdata[95:64];
    assign big = e0[EDGE_W-1] || e1[EDGE_W-1] || e2[EDGE_W-1];

    assign s_tready = !tri_vld_reg || (cidx_reg == 2'd2 && pipe_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tri_vld_reg <= 1'b0;
            cidx_reg    <= '0;
        end else if (s_tvalid && s_tready) begin
            tri_vld_reg <= 1'b1;
            cidx_reg    <= '0;
        end else if (tri_vld_reg && pipe_ready) begin
            if (cidx_reg == 2'd2) begin
                tri_vld_reg <= 1'b0;
                cidx_reg    <= '0;
            end else begin
                cidx_reg <= cidx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            len_reg[0]  <= big ? e0[EDGE_W-1:1] : e0[LEN_W-1:0];
            len_reg[1]  <= big ? e1[EDGE_W-1:1] : e1[LEN_W-1:0];
            len_reg[2]  <= big ? e2[EDGE_W-1:1] : e2[LEN_W-1:0];
            vert_reg[0] <= s_tdata[115:96];
            vert_reg[1] <= s_tdata[135:116];
            vert_reg[2] <= s_tdata[155:136];
        end
    end

    // Pick the corner's opposite and adjacent edges
    always_comb begin
        case (cidx_reg)
            2'd0: begin
                cin = '{opp: len_reg[0], s1: len_reg[1], s2: len_reg[2],
                        vi: vert_reg[1], vj: vert_reg[2], last: 1'b0};
            end
            2'd1: begin
                cin = '{opp: len_reg[1], s1: len_reg[0], s2: len_reg[2],
                        vi: vert_reg[0], vj: vert_reg[2], last: 1'b0};
            end
            default: begin
                cin = '{opp: len_reg[2], s1: len_reg[0], s2: len_reg[1],
                        vi: vert_reg[0], vj: vert_reg[1], last: 1'b1};
            end
        endcase
    end

    clt_corner_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tri_vld_reg),
        .in_ready  (pipe_ready),
        .in_data   (cin),
        .out_valid (pipe_valid),
        .out_ready (hold_take),
        .out_data  (pipe_data)
    );

    // Expand each corner into four triplets
    assign m_fire    = hv_reg && m_tready;
    assign hold_take = !hv_reg || (m_fire && trip_reg == TRIP_JJ);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg   <= 1'b0;
            trip_reg <= TRIP_IJ;
        end else if (hold_take) begin
            hv_reg   <= pipe_valid;
            trip_reg <= TRIP_IJ;
        end else if (m_fire) begin
            trip_reg <= trip_t'(trip_reg + 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_take && pipe_valid) begin
            hold_reg <= pipe_data;
        end
    end

    assign m_tvalid = hv_reg;
    assign m_tuser  = hold_reg.degen;
    assign m_tlast  = hold_reg.last && trip_reg == TRIP_JJ;

    always_comb begin
        case (trip_reg)
            TRIP_IJ: m_tdata = {hold_reg.weight, hold_reg.vj, hold_reg.vi};
            TRIP_JI: m_tdata = {hold_reg.weight, hold_reg.vi, hold_reg.vj};
            TRIP_II: m_tdata = {-hold_reg.weight, hold_reg.vi, hold_reg.vi};
            default: m_tdata = {-hold_reg.weight, hold_reg.vj, hold_reg.vj};
        endcase
    end

`ifndef NO_ASSERTIONS
    // A new triangle is only taken once the previous one has issued all corners
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && tri_vld_reg |-> cidx_reg == 2'd2 && pipe_ready)
        else $error("triangle overwritten before all corners issued");
    // The last triplet of a triangle closes a corner
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> trip_reg == TRIP_JJ)
        else $error("tlast outside the fourth triplet");
    // A corner stays until its fourth triplet is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        hv_reg && !(m_fire && trip_reg == TRIP_JJ) |=> hv_reg && $stable(hold_reg))
        else $error("corner dropped before all triplets sent");
`endif

endmodule
`default_nettype wire
